@@ src/datpl_pkg.sv @@
// shared constants, types and helpers for the double-array trie prefix lookup unit
`default_nettype none

package datpl_pkg;

   // trie memory geometry
   localparam int TRIE_DEPTH = 4096;
   localparam int ADDR_W     = $clog2(TRIE_DEPTH);

   // field widths
   localparam int UNIT_W     = 32;
   localparam int INDEX_W    = 12;
   localparam int KEY_W      = 8;
   localparam int VALUE_W    = 31;
   localparam int UNITS_W    = 13;
   localparam int REPL_W     = 21;
   localparam int POS_W      = 30;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 21;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIE_UNITS        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT_BYTES = 2'd1;

   // request function codes
   localparam logic FUNC_WRITE_UNIT = 1'b0;
   localparam logic FUNC_KEY_BYTE   = 1'b1;

   // unit word layout
   localparam logic [UNIT_W-1:0] LABEL_MASK = 32'h8000_00FF;
   localparam logic [UNIT_W-1:0] VALUE_MASK = 32'h7FFF_FFFF;
   localparam logic [UNIT_W-1:0] WIDE_SHIFT = 32'h0000_0200;
   localparam int LEAF_BIT = 8;

   typedef logic [POS_W-1:0] pos_type;

   // child offset of a unit: upper 22 bits, optionally scaled by 256
   function automatic pos_type node_offset(input logic [UNIT_W-1:0] w);
      pos_type base;
      base = {8'b0, w[UNIT_W-1:10]};
      if ((w & WIDE_SHIFT) != '0) begin
         node_offset = {w[UNIT_W-1:10], 8'b0};
      end else begin
         node_offset = base;
      end
   endfunction

endpackage

`default_nettype wire

@@ src/datpl_ram.sv @@
// generic single-port ram with registered read
`default_nettype none

module datpl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

`default_nettype wire

@@ src/double_array_trie_prefix_lookup_unit.sv @@
// top level of the double-array trie prefix lookup unit
`default_nettype none

// Loads a double-array trie of 32-bit units into an internal single-port
// memory (one unit per write beat, func = 0) and walks it one key byte per
// beat (func = 1). A beat is taken when start is high and busy is low.
// A unit write never raises busy. The first byte of a key reads the root
// unit; each byte of an unresolved key then reads its labelled unit and,
// when the walk reaches a leaf, the leaf value unit: a chain of dependent
// reads through the one memory port with its registered read. Bytes after
// the key is resolved read nothing. Exactly one result per key comes out,
// in the cycle after the last byte finishes, on rsp_valid for a single
// cycle; the receiver cannot stall it, and the result fields read zero
// when rsp_valid is low. Configuration writes are always taken (csr_ready
// is tied high) and must only be issued while the unit is idle. The trie
// memory is not cleared: units must be written before a walk can touch
// them.
module double_array_trie_prefix_lookup_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic                                  req_func,
   input  wire logic [datpl_pkg::INDEX_W-1:0]         req_unit_index,
   input  wire logic [datpl_pkg::UNIT_W-1:0]          req_unit_word,
   input  wire logic [datpl_pkg::KEY_W-1:0]           req_key_byte,
   input  wire logic                                  req_last,
   // result channel
   output logic                                       rsp_valid,
   output logic                                       rsp_found,
   output logic [datpl_pkg::VALUE_W-1:0]              rsp_replacement_offset,
   // configuration channel
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [datpl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [datpl_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // walk sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;  // waiting for a beat
   localparam logic [1:0] ST_ROOT  = 2'd1;  // unit 0 read in flight
   localparam logic [1:0] ST_LABEL = 2'd2;  // labelled unit read in flight
   localparam logic [1:0] ST_LEAF  = 2'd3;  // leaf value read in flight

   logic [1:0]                         state_ff, state_in;
   datpl_pkg::pos_type                 pos_ff, pos_in;
   logic [datpl_pkg::KEY_W-1:0]        key_ff, key_in;
   logic                               last_ff, last_in;
   logic                               started_ff, started_in;
   logic                               resolved_ff, resolved_in;
   logic                               found_ff, found_in;
   logic [datpl_pkg::VALUE_W-1:0]      offset_ff, offset_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_found_ff, rsp_found_in;
   logic [datpl_pkg::VALUE_W-1:0]      rsp_offset_ff, rsp_offset_in;
   logic [datpl_pkg::UNITS_W-1:0]      units_ff, units_in;
   logic [datpl_pkg::REPL_W-1:0]       repl_ff, repl_in;

   // memory port
   logic                               ram_we;
   logic [datpl_pkg::ADDR_W-1:0]       ram_addr;
   logic [datpl_pkg::UNIT_W-1:0]       ram_rdata;

   logic                               accept;
   logic [datpl_pkg::UNITS_W-1:0]      trie_size;
   datpl_pkg::pos_type                 size_ext;
   logic                               wr_in_range;
   logic                               last_now;
   logic                               step_done;
   logic                               res_set;
   logic                               res_hit;
   logic [datpl_pkg::VALUE_W-1:0]      res_val;
   datpl_pkg::pos_type                 walk_pos;
   datpl_pkg::pos_type                 leaf_pos;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // effective trie size, clipped to the memory depth
   assign trie_size = (units_ff > datpl_pkg::UNITS_W'(datpl_pkg::TRIE_DEPTH))
                      ? datpl_pkg::UNITS_W'(datpl_pkg::TRIE_DEPTH) : units_ff;
   assign size_ext  = datpl_pkg::POS_W'(trie_size);

   // writes past the memory are dropped
   assign wr_in_range = (32'(req_unit_index) < 32'(datpl_pkg::TRIE_DEPTH));

   // configuration registers
   always_comb begin
      units_in = units_ff;
      repl_in  = repl_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            datpl_pkg::CSR_TRIE_UNITS: begin
               units_in = csr_wdata[datpl_pkg::UNITS_W-1:0];
            end
            datpl_pkg::CSR_REPLACEMENT_BYTES: begin
               repl_in = csr_wdata[datpl_pkg::REPL_W-1:0];
            end
            default: begin
               units_in = units_ff;
            end
         endcase
      end
   end

   // walk sequencer
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      key_in        = key_ff;
      last_in       = last_ff;
      started_in    = started_ff;
      resolved_in   = resolved_ff;
      found_in      = found_ff;
      offset_in     = offset_ff;
      rsp_valid_in  = 1'b0;
      rsp_found_in  = 1'b0;
      rsp_offset_in = '0;
      ram_we        = 1'b0;
      ram_addr      = pos_ff[datpl_pkg::ADDR_W-1:0];
      step_done     = 1'b0;
      res_set       = 1'b0;
      res_hit       = 1'b0;
      res_val       = '0;
      walk_pos      = '0;
      leaf_pos      = '0;
      last_now      = last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            last_now = req_last;
            if (accept) begin
               if (req_func == datpl_pkg::FUNC_WRITE_UNIT) begin
                  ram_we   = wr_in_range;
                  ram_addr = datpl_pkg::ADDR_W'(req_unit_index);
               end else begin
                  key_in  = req_key_byte;
                  last_in = req_last;
                  if (!started_ff) begin
                     // first byte of a key: fetch the root unit
                     if (trie_size == '0) begin
                        res_set   = 1'b1;
                        step_done = 1'b1;
                     end else begin
                        ram_addr = '0;
                        state_in = ST_ROOT;
                     end
                  end else if (resolved_ff) begin
                     // key already decided, byte is skipped
                     step_done = 1'b1;
                  end else begin
                     walk_pos = pos_ff ^ datpl_pkg::POS_W'(req_key_byte);
                     if (walk_pos >= size_ext) begin
                        res_set   = 1'b1;
                        step_done = 1'b1;
                     end else begin
                        ram_addr = walk_pos[datpl_pkg::ADDR_W-1:0];
                        pos_in   = walk_pos;
                        state_in = ST_LABEL;
                     end
                  end
               end
            end
         end
         ST_ROOT: begin
            walk_pos = datpl_pkg::node_offset(ram_rdata) ^ datpl_pkg::POS_W'(key_ff);
            if (walk_pos >= size_ext) begin
               res_set   = 1'b1;
               step_done = 1'b1;
            end else begin
               ram_addr = walk_pos[datpl_pkg::ADDR_W-1:0];
               pos_in   = walk_pos;
               state_in = ST_LABEL;
            end
         end
         ST_LABEL: begin
            leaf_pos = pos_ff ^ datpl_pkg::node_offset(ram_rdata);
            if ((ram_rdata & datpl_pkg::LABEL_MASK) != datpl_pkg::UNIT_W'(key_ff)) begin
               res_set   = 1'b1;
               step_done = 1'b1;
            end else if (leaf_pos >= size_ext) begin
               res_set   = 1'b1;
               step_done = 1'b1;
            end else begin
               pos_in = leaf_pos;
               if (ram_rdata[datpl_pkg::LEAF_BIT]) begin
                  ram_addr = leaf_pos[datpl_pkg::ADDR_W-1:0];
                  state_in = ST_LEAF;
               end else begin
                  step_done = 1'b1;
               end
            end
         end
         ST_LEAF: begin
            res_val   = datpl_pkg::VALUE_W'(ram_rdata & datpl_pkg::VALUE_MASK);
            res_hit   = (res_val < datpl_pkg::VALUE_W'(repl_ff));
            res_set   = 1'b1;
            step_done = 1'b1;
         end
      endcase

      // record the outcome of the key once decided
      if (res_set) begin
         resolved_in = 1'b1;
         found_in    = res_hit;
         offset_in   = res_hit ? res_val : '0;
      end

      // byte finished: emit on the last byte and rearm for a new key
      if (step_done) begin
         state_in = ST_IDLE;
         if (last_now) begin
            rsp_valid_in  = 1'b1;
            rsp_found_in  = found_in;
            rsp_offset_in = offset_in;
            started_in    = 1'b0;
            resolved_in   = 1'b0;
            found_in      = 1'b0;
            offset_in     = '0;
         end else begin
            started_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         started_ff    <= 1'b0;
         resolved_ff   <= 1'b0;
         found_ff      <= 1'b0;
         offset_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_found_ff  <= 1'b0;
         rsp_offset_ff <= '0;
         units_ff      <= '0;
         repl_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         started_ff    <= started_in;
         resolved_ff   <= resolved_in;
         found_ff      <= found_in;
         offset_ff     <= offset_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_offset_ff <= rsp_offset_in;
         units_ff      <= units_in;
         repl_ff       <= repl_in;
      end
   end

   // walk payload, no reset needed
   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      key_ff  <= key_in;
      last_ff <= last_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_found              = rsp_found_ff;
   assign rsp_replacement_offset = rsp_offset_ff;

   // trie unit store
   datpl_ram #(
      .WIDTH(datpl_pkg::UNIT_W),
      .DEPTH(datpl_pkg::TRIE_DEPTH)
   ) u_trie_ram (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(req_unit_word),
      .rdata(ram_rdata)
   );

endmodule

`default_nettype wire

@@ src/datpl_checker.sv @@
// port-level checker for the double-array trie prefix lookup unit, with its bind
`default_nettype none

module datpl_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              start,
   input wire logic                              busy,
   input wire logic                              req_func,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_found,
   input wire logic [datpl_pkg::VALUE_W-1:0]     rsp_replacement_offset
);

   // result fields are quiet between beats
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> (!rsp_found && rsp_replacement_offset == '0))
      else $error("result fields nonzero without rsp_valid");

   // a miss carries no offset
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_replacement_offset == '0))
      else $error("not-found result carries an offset");

   // only a key byte starts a walk that raises busy
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && req_func == datpl_pkg::FUNC_KEY_BYTE))
      else $error("busy raised without an accepted key byte");

   // a unit write neither raises busy nor produces a result
   a_write_quick: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == datpl_pkg::FUNC_WRITE_UNIT) |=> (!busy && !rsp_valid))
      else $error("unit write caused busy or a result");

   // reset leaves the unit idle and silent
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> (!busy && !rsp_valid))
      else $error("unit not idle after reset");

endmodule

bind double_array_trie_prefix_lookup_unit datpl_checker u_datpl_checker (.*);

`default_nettype wire

@@ bench/double_array_trie_prefix_lookup_unit_tb.sv @@
// self-checking bench for the double-array trie prefix lookup unit: random tries, keys and idling
module double_array_trie_prefix_lookup_unit_tb import datpl_pkg::*; ();

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 12;
   localparam int SETTLE_CYCLES = 6;     // slack for the last byte in flight and its result to land
   localparam int STALL_LIMIT   = 4000;  // cycles with no beat, result or register write
   localparam int MAX_KEYS      = 16;
   localparam int MAX_KEY_LEN   = 8;
   localparam int PHASE_COUNT   = 8;
   localparam int PHASE_BEATS   = 115;   // minimum key bytes per phase
   localparam int MAX_REPORTS   = 40;
   localparam int REPL_MAX      = (1 << REPL_W) - 1;
   localparam int KEY_SHAPES    = 6;

   // register indexes the unit does not decode
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_HI = 2'd3;

   typedef enum int {
      KEY_EXACT, KEY_TRAILING, KEY_SHORT, KEY_MUTATED, KEY_NOISE, KEY_MIDWRITE
   } key_shape_e;

   typedef struct packed {
      logic               found;
      logic [VALUE_W-1:0] offset;
   } lookup_result_t;

   // tracks the unit's trie copy, registers and key walk; holds the lookups owed
   class lookup_tracker;
      logic [UNIT_W-1:0]  units [TRIE_DEPTH];
      logic [UNITS_W-1:0] trie_units;
      logic [REPL_W-1:0]  repl_bytes;
      logic [31:0]        position;
      bit                 in_key;
      bit                 settled;
      bit                 hit;
      logic [VALUE_W-1:0] hit_value;
      lookup_result_t     lookups_due [$];
      int                 failures;

      function new();
         foreach (units[i]) units[i] = '0;
         trie_units = '0;
         repl_bytes = '0;
         position   = '0;
         in_key     = 0;
         settled    = 0;
         hit        = 0;
         hit_value  = '0;
         failures   = 0;
      endfunction

      function int span();
         return (int'(trie_units) > TRIE_DEPTH) ? TRIE_DEPTH : int'(trie_units);
      endfunction

      // upper 22 bits, scaled by 256 when the wide flag is set
      function logic [31:0] child_offset(logic [UNIT_W-1:0] w);
         if ((w & WIDE_SHIFT) != '0) return {2'b00, w[UNIT_W-1:10], 8'h00};
         return {10'b0, w[UNIT_W-1:10]};
      endfunction

      function void settle_key(bit found_it, logic [VALUE_W-1:0] v);
         settled   = 1;
         hit       = found_it;
         hit_value = found_it ? v : '0;
      endfunction

      function void walk_byte(logic [KEY_W-1:0] kb);
         logic [UNIT_W-1:0]  w;
         logic [VALUE_W-1:0] v;
         position = position ^ 32'(kb);
         if (position >= 32'(span())) begin
            settle_key(0, '0);
            return;
         end
         w = units[position[ADDR_W-1:0]];
         if ((w & LABEL_MASK) != 32'(kb)) begin
            settle_key(0, '0);
            return;
         end
         position = position ^ child_offset(w);
         if (position >= 32'(span())) begin
            settle_key(0, '0);
            return;
         end
         if (w[LEAF_BIT]) begin
            v = units[position[ADDR_W-1:0]][VALUE_W-1:0];
            settle_key(v < VALUE_W'(repl_bytes), v);
         end
      endfunction

      function void note_beat(logic func, logic [INDEX_W-1:0] idx, logic [UNIT_W-1:0] word,
                              logic [KEY_W-1:0] kb, logic last);
         if (func == FUNC_WRITE_UNIT) begin
            units[idx] = word;
            return;
         end
         if (!in_key) begin
            in_key    = 1;
            settled   = 0;
            hit       = 0;
            hit_value = '0;
            position  = '0;
            if (span() == 0) settle_key(0, '0);
            else position = child_offset(units[0]);
         end
         if (!settled) walk_byte(kb);
         if (last) begin
            lookups_due.push_back('{found: hit, offset: hit_value});
            in_key    = 0;
            settled   = 0;
            hit       = 0;
            hit_value = '0;
         end
      endfunction

      function void check_lookup(logic found, logic [VALUE_W-1:0] offset);
         lookup_result_t want;
         if (lookups_due.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $error("result with no lookup pending: found %0d replacement_offset 0x%0h",
                      found, offset);
            return;
         end
         want = lookups_due.pop_front();
         if (found !== want.found) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $error("found: expected %0d, got %0d", want.found, found);
         end
         if (offset !== want.offset) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $error("replacement_offset: expected 0x%0h, got 0x%0h", want.offset, offset);
         end
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_TRIE_UNITS:        trie_units = data[UNITS_W-1:0];
            CSR_REPLACEMENT_BYTES: repl_bytes = data[REPL_W-1:0];
            default: ;
         endcase
      endfunction

      function int lookups_waiting();
         return lookups_due.size();
      endfunction
   endclass

   // clock, reset and every block input start known
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic                   req_func       = FUNC_WRITE_UNIT;
   logic [INDEX_W-1:0]     req_unit_index = '0;
   logic [UNIT_W-1:0]      req_unit_word  = '0;
   logic [KEY_W-1:0]       req_key_byte   = '0;
   logic                   req_last       = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_found;
   logic [VALUE_W-1:0]     rsp_replacement_offset;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   lookup_tracker tracker = new();

   // trie image the stimulus is built from, with the keys known to reach a leaf
   logic [UNIT_W-1:0] image [TRIE_DEPTH];
   bit                taken [TRIE_DEPTH];
   int                parent_of [TRIE_DEPTH];
   int                base_of [TRIE_DEPTH];
   logic [KEY_W-1:0]  key_bytes [MAX_KEYS][MAX_KEY_LEN];
   int                key_len [MAX_KEYS];
   int                n_keys = 0;
   logic [KEY_W-1:0]  key_buf [MAX_KEY_LEN];

   int idle_pct     = 0;   // chance in a hundred that the sender idles a cycle
   int cur_eff      = 0;   // trie size in use for this phase
   int quiet_cycles = 0;

   double_array_trie_prefix_lookup_unit dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_func               (req_func),
      .req_unit_index         (req_unit_index),
      .req_unit_word          (req_unit_word),
      .req_key_byte           (req_key_byte),
      .req_last               (req_last),
      .rsp_valid              (rsp_valid),
      .rsp_found              (rsp_found),
      .rsp_replacement_offset (rsp_replacement_offset),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // everything the block takes or gives is seen here, at the edge that moves it
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            tracker.note_beat(req_func, req_unit_index, req_unit_word, req_key_byte, req_last);
         if (rsp_valid)
            tracker.check_lookup(rsp_found, rsp_replacement_offset);
         if (csr_valid && csr_ready)
            tracker.write_register(csr_index, csr_wdata);
         // watchdog: any beat, result or register write counts as progress
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // unit word with a given label, leaf flag and child offset; wide form at random when it fits
   function automatic logic [UNIT_W-1:0] unit_word_for(logic [KEY_W-1:0] label, bit leaf,
                                                        int off);
      logic [UNIT_W-1:0] w;
      if (off[7:0] == 8'h00 && $urandom_range(1) == 1) w = (32'(off) >> 8 << 10) | WIDE_SHIFT;
      else w = 32'(off) << 10;
      return w | 32'(label) | (32'(leaf) << LEAF_BIT);
   endfunction

   // leaf value below, at or above the replacement size; top bit is don't-care
   function automatic logic [UNIT_W-1:0] leaf_value_word(int repl);
      logic [VALUE_W-1:0] v;
      case ($urandom_range(3))
         0:       v = (repl > 0) ? VALUE_W'($urandom_range(repl - 1)) : '0;
         1:       v = VALUE_W'(repl);
         2:       v = VALUE_W'($urandom);
         default: v = VALUE_W'(repl + int'($urandom_range(3)));
      endcase
      return {1'($urandom), v};
   endfunction

   // random filler plus a handful of keys threaded through it
   function automatic void build_trie(int eff, int repl);
      int root, p, u, q, len, d, tries;
      bit ok;
      logic [KEY_W-1:0] kb;
      n_keys = 0;
      for (int i = 0; i < eff; i++) begin
         image[i]     = $urandom;
         taken[i]     = 0;
         parent_of[i] = -1;
         base_of[i]   = -1;
      end
      if (eff == 0) return;
      root     = $urandom_range(eff - 1);
      image[0] = unit_word_for(KEY_W'($urandom), 1'($urandom), root);
      taken[0] = 1;
      for (tries = 0; tries < 48 && n_keys < MAX_KEYS; tries++) begin
         len = $urandom_range(1, 4);
         p   = root;
         ok  = 1;
         for (d = 0; d < len && ok; d++) begin
            kb = $urandom;
            u  = p ^ int'(kb);
            key_bytes[n_keys][d] = kb;
            if (u >= eff) begin
               ok = 0;
            end else if (taken[u]) begin
               // share an inner node of an earlier key, never its leaf
               if (parent_of[u] == p && base_of[u] >= 0 && d < len - 1) p = base_of[u];
               else ok = 0;
            end else if (d == len - 1) begin
               q = $urandom_range(eff - 1);
               if (taken[q] || q == u) begin
                  ok = 0;
               end else begin
                  taken[u]     = 1;
                  taken[q]     = 1;
                  parent_of[u] = p;
                  image[u]     = unit_word_for(kb, 1, u ^ q);
                  image[q]     = leaf_value_word(repl);
               end
            end else begin
               q            = $urandom_range(eff - 1);
               taken[u]     = 1;
               parent_of[u] = p;
               base_of[u]   = q;
               image[u]     = unit_word_for(kb, 0, u ^ q);
               p            = q;
            end
         end
         if (ok) begin
            key_len[n_keys] = len;
            n_keys++;
         end
      end
   endfunction

   // one beat on the request side; start stays high between back-to-back beats
   task automatic issue_beat(logic func, logic [INDEX_W-1:0] idx, logic [UNIT_W-1:0] word,
                             logic [KEY_W-1:0] kb, logic last);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start          <= 1'b1;
      req_func       <= func;
      req_unit_index <= idx;
      req_unit_word  <= word;
      req_key_byte   <= kb;
      req_last       <= last;
      do @(posedge clock); while (busy);
   endtask

   // unused key fields carry junk on a write
   task automatic send_write(int idx, logic [UNIT_W-1:0] word);
      issue_beat(FUNC_WRITE_UNIT, INDEX_W'(idx), word, KEY_W'($urandom), 1'($urandom));
   endtask

   // sender holds off until every lookup is back, then lets the pipe empty
   task automatic wait_lookups_done();
      start <= 1'b0;
      while (tracker.lookups_waiting() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // both registers plus one index that decodes to nothing, back to back
   task automatic program_registers(int units_val, int repl_val);
      logic [CSR_DATA_W-1:0] data;
      data                = CSR_DATA_W'($urandom);
      data[UNITS_W-1:0]   = UNITS_W'(units_val);
      csr_valid <= 1'b1;
      csr_index <= CSR_TRIE_UNITS;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_REPLACEMENT_BYTES;
      csr_wdata <= CSR_DATA_W'(repl_val);
      do @(posedge clock); while (!csr_ready);
      csr_index <= ($urandom_range(1) == 1) ? CSR_UNMAPPED_HI : CSR_UNMAPPED_LO;
      csr_wdata <= CSR_DATA_W'($urandom);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // a unit rewritten while a key is open; sometimes the same word, sometimes a new one
   task automatic mid_key_write();
      int idx;
      logic [UNIT_W-1:0] word;
      if (cur_eff > 0 && $urandom_range(1) == 1) idx = $urandom_range(cur_eff - 1);
      else idx = $urandom_range(TRIE_DEPTH - 1);
      if (idx >= cur_eff || $urandom_range(3) == 0) word = $urandom;
      else word = image[idx];
      image[idx] = word;
      send_write(idx, word);
   endtask

   task automatic send_bytes(int len, int wr_at);
      for (int d = 0; d < len; d++) begin
         issue_beat(FUNC_KEY_BYTE, INDEX_W'($urandom), $urandom, key_buf[d], 1'(d == len - 1));
         if (d == wr_at) mid_key_write();
      end
   endtask

   task automatic send_key(key_shape_e shape, inout int beats);
      int sel, len, wr_at, extra, d;
      if (n_keys == 0) shape = KEY_NOISE;
      sel = (n_keys > 0) ? int'($urandom_range(n_keys - 1)) : 0;
      if (shape == KEY_NOISE) begin
         len = $urandom_range(1, 5);
         for (d = 0; d < len; d++) key_buf[d] = $urandom;
      end else begin
         len = key_len[sel];
         for (d = 0; d < len; d++) key_buf[d] = key_bytes[sel][d];
      end
      case (shape)
         // bytes after the leaf are ignored
         KEY_TRAILING: begin
            extra = $urandom_range(1, 3);
            for (d = len; d < len + extra; d++) key_buf[d] = $urandom;
            len += extra;
         end
         // key ends before its leaf
         KEY_SHORT: if (len > 1) len--;
         // label mismatch somewhere along the path
         KEY_MUTATED: begin
            d          = $urandom_range(len - 1);
            key_buf[d] = key_buf[d] ^ KEY_W'($urandom_range(1, 255));
         end
         default: ;
      endcase
      wr_at = -1;
      if (len > 1 && (shape == KEY_MIDWRITE || $urandom_range(29) == 0))
         wr_at = $urandom_range(len - 2);
      send_bytes(len, wr_at);
      beats += len;
   endtask

   function automatic key_shape_e pick_shape();
      int r;
      r = $urandom_range(99);
      if (r < 40) return KEY_EXACT;
      if (r < 52) return KEY_TRAILING;
      if (r < 62) return KEY_SHORT;
      if (r < 72) return KEY_MUTATED;
      if (r < 92) return KEY_NOISE;
      return KEY_MIDWRITE;
   endfunction

   initial begin
      // trie sizes: small, single unit, empty, full depth and beyond it
      int span_cfg [PHASE_COUNT] = '{16, 1, 64, 0, 300, 4096, 8191, 40};
      // negative picks a random replacement size
      int repl_cfg [PHASE_COUNT] = '{REPL_MAX, 1, -1, 5, 1048576, -1, REPL_MAX, 0};
      int idle_cfg [3]           = '{0, 71, 17};
      int units_val, repl_val, eff, prev_eff, beats, n;
      key_shape_e shape;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // empty trie straight out of reset: every key misses
      key_buf[0] = 8'h00;
      send_bytes(1, -1);
      key_buf[0] = 8'hFF;
      key_buf[1] = 8'h80;
      send_bytes(2, -1);
      key_buf[2] = 8'h7F;
      send_bytes(3, 0);
      send_write(TRIE_DEPTH - 1, 32'hFFFF_FFFF);
      send_write(0, 32'h0000_0000);

      prev_eff = -1;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         idle_pct = idle_cfg[phase % 3];
         wait_lookups_done();
         units_val = span_cfg[phase];
         repl_val  = (repl_cfg[phase] < 0) ? int'($urandom_range(REPL_MAX)) : repl_cfg[phase];
         program_registers(units_val, repl_val);
         eff     = (units_val > TRIE_DEPTH) ? TRIE_DEPTH : units_val;
         cur_eff = eff;
         // every unit a walk can reach is written before the first key byte
         if (eff != prev_eff) begin
            build_trie(eff, repl_val);
            for (int i = 0; i < eff; i++) send_write(i, image[i]);
            prev_eff = eff;
         end
         beats = 0;
         n     = 0;
         while (beats < PHASE_BEATS) begin
            // first phase opens with one key of each shape
            if (phase == 0 && n < KEY_SHAPES) shape = key_shape_e'(n);
            else shape = pick_shape();
            send_key(shape, beats);
            n++;
            if ($urandom_range(24) == 0) wait_lookups_done();
         end
      end

      wait_lookups_done();
      if (tracker.failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
